>>> rtl/tlc_pkg.sv
// traffic light countdown package: item types, register map, lamp and segment constants
// no dependencies

package tlc_pkg;

  localparam int TICK_W  = 16;
  localparam int ARST_W  = 2;
  localparam int BPAUS_W = 3;
  localparam int LAMP_W  = 6;
  localparam int SEG_W   = 7;
  localparam int DIGIT_W = 4;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [1:0] REG_TICKS_PER_STEP   = 2'd0;
  localparam logic [1:0] REG_PRESSES_TO_RESET = 2'd1;
  localparam logic [1:0] REG_PRESSES_TO_PAUSE = 2'd2;

  localparam logic [TICK_W-1:0]  TICKS_PER_STEP_RST   = 16'd1000;
  localparam logic [ARST_W-1:0]  PRESSES_TO_RESET_RST = 2'd2;
  localparam logic [BPAUS_W-1:0] PRESSES_TO_PAUSE_RST = 3'd3;

  localparam logic [LAMP_W-1:0]  LAMPS_A   = 6'h28;
  localparam logic [LAMP_W-1:0]  LAMPS_B   = 6'h14;
  localparam logic [DIGIT_W-1:0] DIGIT_TOP = 4'd9;
  localparam logic [SEG_W-1:0]   SEG_BLANK = 7'h7f;

  typedef struct packed {
    logic button_a;
    logic button_b;
  } in_item_t;

  typedef struct packed {
    logic [LAMP_W-1:0] light_pattern;
    logic [SEG_W-1:0]  segment_code;
    logic              refreshed;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0]  ticks_per_step;
    logic [ARST_W-1:0]  presses_to_reset;
    logic [BPAUS_W-1:0] presses_to_pause;
  } cfg_t;

  // active-low segment code of one digit
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    begin
      case (d)
        4'd0:    s = 7'b0000001;
        4'd1:    s = 7'b1001111;
        4'd2:    s = 7'b0010010;
        4'd3:    s = 7'b0000110;
        4'd4:    s = 7'b1001100;
        4'd5:    s = 7'b0100100;
        4'd6:    s = 7'b0100000;
        4'd7:    s = 7'b0001111;
        4'd8:    s = 7'b0000000;
        4'd9:    s = 7'b0000100;
        default: s = SEG_BLANK;
      endcase
      return s;
    end
  endfunction

endpackage

>>> rtl/traffic_light_countdown.sv
// traffic light countdown top level: input register, state update, result register
// items pass the input register, then the result register; one item per cycle sustained
// when out_stall stays low; throughput is set by the state update in tlc_core
// synchronous active-low reset clears the pipeline valid flags and counts, sets lamps 0x28 and digit 9
// depends on tlc_pkg, tlc_cfg, tlc_core

module traffic_light_countdown import tlc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg;
  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t result;
  logic      advance;
  logic      in_take;

  tlc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tlc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .btn    (in_data_r),
    .cfg    (cfg),
    .result (result)
  );

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");

  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("processed item did not produce a result");

  a_refresh_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.refreshed) |->
      (out_data.light_pattern == LAMPS_A || out_data.light_pattern == LAMPS_B))
    else $error("refresh shows an unexpected lamp pattern");

  a_refresh_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.refreshed) |-> (out_data.segment_code != SEG_BLANK))
    else $error("refresh shows a digit outside 0..9");

endmodule

>>> rtl/tlc_cfg.sv
// traffic light countdown configuration registers behind an apb-style port
// depends on tlc_pkg

module tlc_cfg import tlc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_TICKS_PER_STEP:   cfg_nxt.ticks_per_step   = pwdata[TICK_W-1:0];
        REG_PRESSES_TO_RESET: cfg_nxt.presses_to_reset = pwdata[ARST_W-1:0];
        REG_PRESSES_TO_PAUSE: cfg_nxt.presses_to_pause = pwdata[BPAUS_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TICKS_PER_STEP:   prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_r.ticks_per_step};
      REG_PRESSES_TO_RESET: prdata = {{(DATA_W-ARST_W){1'b0}}, cfg_r.presses_to_reset};
      REG_PRESSES_TO_PAUSE: prdata = {{(DATA_W-BPAUS_W){1'b0}}, cfg_r.presses_to_pause};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_step   <= TICKS_PER_STEP_RST;
      cfg_r.presses_to_reset <= PRESSES_TO_RESET_RST;
      cfg_r.presses_to_pause <= PRESSES_TO_PAUSE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/tlc_core.sv
// traffic light countdown state: button events, release counts, pause, digit and lamps
// depends on tlc_pkg

module tlc_core import tlc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  btn,
  input  cfg_t      cfg,
  output out_item_t result
);

  logic               a_held_r, a_held_nxt;
  logic               b_held_r, b_held_nxt;
  logic               paused_r, paused_nxt;
  logic [ARST_W-1:0]  a_rel_r, a_rel_nxt;
  logic [BPAUS_W-1:0] b_rel_r, b_rel_nxt;
  logic [LAMP_W-1:0]  lamp_r, lamp_nxt;
  logic [DIGIT_W-1:0] digit_r, digit_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [LAMP_W-1:0]  shown_lamps_r, shown_lamps_nxt;
  logic [SEG_W-1:0]   shown_seg_r, shown_seg_nxt;
  logic               refreshed;
  logic [BPAUS_W-1:0] resume_cnt;
  logic [TICK_W-1:0]  limit;

  assign resume_cnt = cfg.presses_to_pause + 3'd1;
  assign limit      = cfg.ticks_per_step - 16'd1;

  always_comb begin
    a_held_nxt      = a_held_r;
    b_held_nxt      = b_held_r;
    paused_nxt      = paused_r;
    a_rel_nxt       = a_rel_r;
    b_rel_nxt       = b_rel_r;
    lamp_nxt        = lamp_r;
    digit_nxt       = digit_r;
    shown_lamps_nxt = shown_lamps_r;
    shown_seg_nxt   = shown_seg_r;
    refreshed       = 1'b0;

    // one button event per item, by priority
    if (btn.button_a && !a_held_r) begin
      a_held_nxt = 1'b1;
    end else if (btn.button_b && !b_held_r) begin
      b_held_nxt = 1'b1;
    end else if (!btn.button_a && a_held_r) begin
      a_rel_nxt  = a_rel_r + 2'd1;
      a_held_nxt = 1'b0;
    end else if (!btn.button_b && b_held_r) begin
      b_rel_nxt  = b_rel_r + 3'd1;
      b_held_nxt = 1'b0;
    end

    if (a_rel_nxt == cfg.presses_to_reset) begin
      a_rel_nxt = '0;
      lamp_nxt  = LAMPS_B;
      digit_nxt = DIGIT_TOP;
    end

    if (b_rel_nxt == cfg.presses_to_pause) begin
      paused_nxt = 1'b1;
    end
    if (b_rel_nxt == resume_cnt) begin
      b_rel_nxt  = '0;
      paused_nxt = 1'b0;
    end

    if (tick_r == '0 && !paused_nxt) begin
      shown_lamps_nxt = lamp_nxt;
      shown_seg_nxt   = seg_of(digit_nxt);
      refreshed       = 1'b1;
      if (digit_nxt == '0) begin
        digit_nxt = DIGIT_TOP;
        lamp_nxt  = (lamp_nxt == LAMPS_B) ? {lamp_nxt[LAMP_W-2:0], 1'b0}
                                          : {1'b0, lamp_nxt[LAMP_W-1:1]};
      end else begin
        digit_nxt = digit_nxt - 4'd1;
      end
    end
  end

  assign tick_nxt = (tick_r < limit) ? (tick_r + 16'd1) : '0;

  assign result.light_pattern = shown_lamps_nxt;
  assign result.segment_code  = shown_seg_nxt;
  assign result.refreshed     = refreshed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_held_r      <= 1'b0;
      b_held_r      <= 1'b0;
      paused_r      <= 1'b0;
      a_rel_r       <= '0;
      b_rel_r       <= '0;
      lamp_r        <= LAMPS_A;
      digit_r       <= DIGIT_TOP;
      tick_r        <= '0;
      shown_lamps_r <= '0;
      shown_seg_r   <= '0;
    end else if (step) begin
      a_held_r      <= a_held_nxt;
      b_held_r      <= b_held_nxt;
      paused_r      <= paused_nxt;
      a_rel_r       <= a_rel_nxt;
      b_rel_r       <= b_rel_nxt;
      lamp_r        <= lamp_nxt;
      digit_r       <= digit_nxt;
      tick_r        <= tick_nxt;
      shown_lamps_r <= shown_lamps_nxt;
      shown_seg_r   <= shown_seg_nxt;
    end
  end

endmodule
